// ----- rtl/core/esd_pkg.sv -----
package esd_pkg;

    localparam int CntW   = 13;
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);

    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChN      = 8'h6E;
    localparam logic [7:0] ChR      = 8'h72;
    localparam logic [7:0] ChT      = 8'h74;
    localparam logic [7:0] ChE      = 8'h65;
    localparam logic [7:0] ChX      = 8'h78;
    localparam logic [7:0] ChNul    = 8'h00;
    localparam logic [7:0] CodeLf   = 8'h0A;
    localparam logic [7:0] CodeCr   = 8'h0D;
    localparam logic [7:0] CodeTab  = 8'h09;
    localparam logic [7:0] CodeEsc  = 8'h1B;

    typedef enum logic [2:0] {
        MODE_LIT  = 3'd0,
        MODE_ESC  = 3'd1,
        MODE_HEX0 = 3'd2,
        MODE_HEX1 = 3'd3,
        MODE_OCT1 = 3'd4,
        MODE_OCT2 = 3'd5
    } mode_t;

    typedef struct packed {
        logic [7:0]      data;
        logic            valid;
        logic            last;
        logic [CntW-1:0] count;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t res0;
        result_t res1;
    } cmd_t;

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66))
            || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c <= 8'h39)
            begin
                v = c - 8'h30;
            end
            else if (c >= 8'h61)
            begin
                v = c - 8'h61 + 8'd10;
            end
            else
            begin
                v = c - 8'h41 + 8'd10;
            end
            return v[3:0];
        end
    endfunction

endpackage

// ----- rtl/core/esd_front.sv -----
module esd_front
    import esd_pkg::*;
#(
    parameter int MAX_BYTES = 4096
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  logic [CntW-1:0] max_len,
    output logic            push,
    output cmd_t            cmd
);

    localparam int CapInt = (MAX_BYTES > (2**CntW - 1)) ? (2**CntW - 1) : MAX_BYTES;
    localparam logic [CntW-1:0] Cap = CntW'(CapInt);

    mode_t           mode_reg, mode_next, mode_dec;
    logic [8:0]      pv_reg, pv_next, pv_dec;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [CntW-1:0] lim, c0, c1;
    logic            is_end, lit_emit, flush;
    logic            a_v, b_v, s0_v, s1_v, e0, e1;
    logic [7:0]      a_d, s0_d, s1_d;
    mode_t           lit_mode;

    assign is_end   = (in_byte == ChNul) || in_last;
    assign lit_emit = (in_byte != ChBslash);
    assign lit_mode = (in_byte == ChBslash) ? MODE_ESC : MODE_LIT;
    assign lim      = (max_len < Cap) ? max_len : Cap;

    // next state of the mode machine
    always_comb
    begin
        mode_dec = mode_reg;
        if (in_byte != ChNul)
        begin
            unique case (mode_reg)
                MODE_ESC:
                begin
                    if (in_byte == ChX)
                        mode_dec = MODE_HEX0;
                    else if (is_oct(in_byte))
                        mode_dec = MODE_OCT1;
                    else
                        mode_dec = MODE_LIT;
                end
                MODE_HEX0: mode_dec = is_hex(in_byte) ? MODE_HEX1 : lit_mode;
                MODE_HEX1: mode_dec = is_hex(in_byte) ? MODE_LIT : lit_mode;
                MODE_OCT1: mode_dec = is_oct(in_byte) ? MODE_OCT2 : lit_mode;
                MODE_OCT2: mode_dec = is_oct(in_byte) ? MODE_LIT : lit_mode;
                default:   mode_dec = lit_mode;
            endcase
        end
    end

    // bytes produced by the mode machine
    always_comb
    begin
        a_v    = 1'b0;
        a_d    = in_byte;
        b_v    = 1'b0;
        pv_dec = pv_reg;
        if (in_byte != ChNul)
        begin
            unique case (mode_reg)
                MODE_ESC:
                begin
                    unique case (in_byte)
                        ChN:
                        begin
                            a_v = 1'b1;
                            a_d = CodeLf;
                        end
                        ChR:
                        begin
                            a_v = 1'b1;
                            a_d = CodeCr;
                        end
                        ChT:
                        begin
                            a_v = 1'b1;
                            a_d = CodeTab;
                        end
                        ChE:
                        begin
                            a_v = 1'b1;
                            a_d = CodeEsc;
                        end
                        ChX: a_v = 1'b0;
                        default:
                        begin
                            if (is_oct(in_byte))
                                pv_dec = {6'd0, in_byte[2:0]};
                            else
                                a_v = 1'b1;
                        end
                    endcase
                end
                MODE_HEX0:
                begin
                    if (is_hex(in_byte))
                        pv_dec = {5'd0, hex_val(in_byte)};
                    else
                        a_v = lit_emit;
                end
                MODE_HEX1:
                begin
                    a_v = 1'b1;
                    if (is_hex(in_byte))
                    begin
                        a_d = {pv_reg[3:0], hex_val(in_byte)};
                    end
                    else
                    begin
                        a_d = pv_reg[7:0];
                        b_v = lit_emit;
                    end
                end
                MODE_OCT1, MODE_OCT2:
                begin
                    if (is_oct(in_byte))
                    begin
                        pv_dec = {pv_reg[5:0], in_byte[2:0]};
                        a_v    = (mode_reg == MODE_OCT2);
                        a_d    = pv_dec[7:0];
                    end
                    else
                    begin
                        a_v = 1'b1;
                        a_d = pv_reg[7:0];
                        b_v = lit_emit;
                    end
                end
                default: a_v = lit_emit;
            endcase
        end
    end

    assign flush = is_end && ((mode_dec == MODE_HEX1) || (mode_dec == MODE_OCT1)
                              || (mode_dec == MODE_OCT2));

    // pending value fills the first free slot at end of string
    always_comb
    begin
        s0_v = a_v || flush;
        s0_d = a_v ? a_d : pv_dec[7:0];
        s1_v = a_v && (b_v || flush);
        s1_d = b_v ? in_byte : pv_dec[7:0];
    end

    assign e0 = s0_v && (cnt_reg < lim);
    assign c0 = cnt_reg + CntW'(e0);
    assign e1 = s1_v && (c0 < lim);
    assign c1 = c0 + CntW'(e1);

    always_comb
    begin
        cmd.two         = e1;
        cmd.res0.data   = e0 ? s0_d : 8'd0;
        cmd.res0.valid  = e0;
        cmd.res0.last   = is_end && !e1;
        cmd.res0.count  = c0;
        cmd.res1.data   = s1_d;
        cmd.res1.valid  = 1'b1;
        cmd.res1.last   = is_end;
        cmd.res1.count  = c1;
    end

    assign push = accept && (e0 || is_end);

    always_comb
    begin
        mode_next = mode_reg;
        pv_next   = pv_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            mode_next = is_end ? MODE_LIT : mode_dec;
            pv_next   = is_end ? 9'd0 : pv_dec;
            cnt_next  = is_end ? '0 : c1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LIT;
            pv_reg   <= 9'd0;
            cnt_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            pv_reg   <= pv_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/esd_queue.sv -----
module esd_queue
    import esd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty
);

    cmd_t             mem_reg [QDepth];
    logic [QPtrW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QPtrW:0]   fill_reg, fill_next;

    assign full     = (fill_reg == (QPtrW+1)'(QDepth));
    assign empty    = (fill_reg == '0);
    assign head_cmd = mem_reg[rd_reg];

    always_comb
    begin
        wr_next   = push ? wr_reg + 1'b1 : wr_reg;
        rd_next   = pop ? rd_reg + 1'b1 : rd_reg;
        fill_next = fill_reg + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ----- rtl/core/esd_back.sv -----
module esd_back
    import esd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    head_cmd,
    input  logic    empty,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    sel_reg, sel_next;
    logic    ov_reg, ov_next;
    logic    load;
    result_t res_reg, res_next;

    assign load = !ov_reg || out_ready;
    assign pop  = load && !empty && (sel_reg || !head_cmd.two);

    always_comb
    begin
        ov_next  = ov_reg;
        sel_next = sel_reg;
        res_next = res_reg;
        if (load)
        begin
            ov_next = !empty;
            if (!empty)
            begin
                res_next = sel_reg ? head_cmd.res1 : head_cmd.res0;
                sel_next = !sel_reg && head_cmd.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            sel_reg <= 1'b0;
        end
        else
        begin
            ov_reg  <= ov_next;
            sel_reg <= sel_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_res   = res_reg;

endmodule

// ----- rtl/core/escape_sequence_decoder_top.sv -----
// Decodes a C-style escaped string, one character per transfer, into raw bytes.
// The front end takes one character every cycle while its four-entry command
// queue has room. A character yields no, one or two result transfers. The
// output stage sends one result per cycle while m_axis_tready is high, so a
// character that flushes a pending hex or octal value and is itself emitted
// needs two transfers, each registered at the output stage. tuser low marks a
// bare end-of-string marker; tlast flags the final result of each string.
// A write on cfg_we sets the output byte limit per string, capped at MAX_BYTES.
module escape_sequence_decoder_top
    import esd_pkg::*;
#(
    parameter int MAX_BYTES = 4096
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [CntW-1:0] cfg_wdata,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,   // in_byte
    input  logic            s_axis_tlast,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [23:0]     m_axis_tdata,   // out_byte, out_count, zero pad
    output logic            m_axis_tuser,   // out_valid
    output logic            m_axis_tlast
);

    logic [CntW-1:0] max_len_reg;
    logic            accept, push, full, pop, empty;
    cmd_t            push_cmd, head_cmd;
    result_t         out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= CntW'(4096);
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    esd_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_axis_tdata),
        .in_last (s_axis_tlast),
        .max_len (max_len_reg),
        .push    (push),
        .cmd     (push_cmd)
    );

    esd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty)
    );

    esd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {3'd0, out_res.count, out_res.data};
    assign m_axis_tuser = out_res.valid;
    assign m_axis_tlast = out_res.last;

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into full queue");

    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("bare end marker without tlast");

    a_byte_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> out_res.count != '0)
        else $error("decoded byte with zero count");

endmodule

// ----- bench/tb_escape_sequence_decoder_top.sv -----
`timescale 1ns / 1ps

module tb_escape_sequence_decoder_top;
    import esd_pkg::*;

    localparam int MaxBytes = 4096;
    localparam int SegItems = 130;
    localparam logic [7:0] ChQuote = 8'h22;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_t;

    logic            clk;
    logic            rst_n = 1'b0;
    logic            cfg_we = 1'b0;
    logic [CntW-1:0] cfg_wdata = '0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [7:0]      s_axis_tdata = '0;   // in_byte
    logic            s_axis_tlast = 1'b0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [23:0]     m_axis_tdata;        // out_byte, out_count, zero pad
    logic            m_axis_tuser;        // out_valid
    logic            m_axis_tlast;

    char_t   chars_q[$];
    result_t expected_q[$];
    int      n_pushed = 0;
    int      n_taken = 0;
    int      n_fail = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    logic    rx_hold = 1'b0;
    logic    in_taken = 1'b0;

    // decoder state as predicted
    mode_t           esc_mode = MODE_LIT;
    logic [8:0]      pend = '0;
    logic [CntW-1:0] out_cnt = '0;
    logic [CntW-1:0] max_len_q = 13'd4096;
    result_t         char_res[2];
    int              n_res;

    escape_sequence_decoder_top #(
        .MAX_BYTES(MaxBytes)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return c - "0";
        end
        if (c >= "a" && c <= "f")
        begin
            return c - "a" + 10;
        end
        if (c >= "A" && c <= "F")
        begin
            return c - "A" + 10;
        end
        return -1;
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return c >= "0" && c <= "7";
    endfunction

    function automatic void emit_decoded(input logic [7:0] b);
        int lim;
        lim = (max_len_q < MaxBytes) ? max_len_q : MaxBytes;
        if (out_cnt >= lim || n_res >= 2)
        begin
            return;
        end
        out_cnt++;
        char_res[n_res] = '{data: b, valid: 1'b1, last: 1'b0, count: out_cnt};
        n_res++;
    endfunction

    function automatic void take_literal(input logic [7:0] b);
        if (b == ChBslash)
        begin
            esc_mode = MODE_ESC;
        end
        else
        begin
            emit_decoded(b);
        end
    endfunction

    function automatic void decode_char(input logic [7:0] b);
        int h;
        case (esc_mode)
            MODE_ESC:
            begin
                esc_mode = MODE_LIT;
                case (b)
                    ChN: emit_decoded(CodeLf);
                    ChR: emit_decoded(CodeCr);
                    ChT: emit_decoded(CodeTab);
                    ChE: emit_decoded(CodeEsc);
                    ChX: esc_mode = MODE_HEX0;
                    default:
                    begin
                        if (is_octal(b))
                        begin
                            pend = {6'd0, b[2:0]};
                            esc_mode = MODE_OCT1;
                        end
                        else
                        begin
                            emit_decoded(b);
                        end
                    end
                endcase
            end
            MODE_HEX0:
            begin
                h = hex_nibble(b);
                if (h >= 0)
                begin
                    pend = 9'(h);
                    esc_mode = MODE_HEX1;
                end
                else
                begin
                    esc_mode = MODE_LIT;
                    take_literal(b);
                end
            end
            MODE_HEX1:
            begin
                h = hex_nibble(b);
                esc_mode = MODE_LIT;
                if (h >= 0)
                begin
                    emit_decoded({pend[3:0], h[3:0]});
                end
                else
                begin
                    emit_decoded(pend[7:0]);
                    take_literal(b);
                end
            end
            MODE_OCT1, MODE_OCT2:
            begin
                if (is_octal(b))
                begin
                    pend = {pend[5:0], b[2:0]};
                    if (esc_mode == MODE_OCT1)
                    begin
                        esc_mode = MODE_OCT2;
                    end
                    else
                    begin
                        esc_mode = MODE_LIT;
                        emit_decoded(pend[7:0]);
                    end
                end
                else
                begin
                    esc_mode = MODE_LIT;
                    emit_decoded(pend[7:0]);
                    take_literal(b);
                end
            end
            default:
            begin
                esc_mode = MODE_LIT;
                take_literal(b);
            end
        endcase
    endfunction

    // works out the result transfers caused by one character
    function automatic void predict_char(input logic [7:0] b, input logic last);
        n_res = 0;
        if (b != ChNul)
        begin
            decode_char(b);
        end
        if (b == ChNul || last)
        begin
            if (esc_mode == MODE_HEX1 || esc_mode == MODE_OCT1 || esc_mode == MODE_OCT2)
            begin
                emit_decoded(pend[7:0]);
            end
            if (n_res == 0)
            begin
                char_res[0] = '{data: 8'h00, valid: 1'b0, last: 1'b1, count: out_cnt};
                n_res = 1;
            end
            else
            begin
                char_res[n_res - 1].last = 1'b1;
            end
            esc_mode = MODE_LIT;
            pend = '0;
            out_cnt = '0;
        end
        for (int i = 0; i < n_res; i++)
        begin
            expected_q.push_back(char_res[i]);
        end
    endfunction

    // input side
    always @(posedge clk)
    begin
        in_taken = s_axis_tvalid && s_axis_tready;
        if (in_taken)
        begin
            predict_char(s_axis_tdata, s_axis_tlast);
            chars_q.pop_front();
            n_taken++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (chars_q.size() > 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= chars_q[0].ch;
                s_axis_tlast  <= chars_q[0].last;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side
    always @(negedge clk)
    begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transfer: byte %0h count %0d",
                    m_axis_tdata[7:0], m_axis_tdata[20:8]);
                n_fail++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_axis_tdata[7:0] !== want.data)
                begin
                    $error("out_byte: expected %0h, got %0h", want.data, m_axis_tdata[7:0]);
                    n_fail++;
                end
                if (m_axis_tuser !== want.valid)
                begin
                    $error("out_valid: expected %0b, got %0b", want.valid, m_axis_tuser);
                    n_fail++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("out_last: expected %0b, got %0b", want.last, m_axis_tlast);
                    n_fail++;
                end
                if (m_axis_tdata[20:8] !== want.count)
                begin
                    $error("out_count: expected %0d, got %0d", want.count, m_axis_tdata[20:8]);
                    n_fail++;
                end
            end
        end
    end

    // long receiver stall so the command queue fills and the input backs up
    initial
    begin
        wait (n_taken >= 640);
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic queue_char(input logic [7:0] b, input logic last);
        chars_q.push_back('{ch: b, last: last});
        n_pushed++;
    endtask

    task automatic push_text(input string txt, input logic end_last);
        for (int i = 0; i < txt.len(); i++)
        begin
            queue_char(txt[i], end_last && (i == txt.len() - 1));
        end
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10)
        begin
            return 8'("0" + v);
        end
        return $urandom_range(1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
    endfunction

    function automatic logic [7:0] plain_escape();
        case ($urandom_range(5))
            0: return ChN;
            1: return ChR;
            2: return ChT;
            3: return ChE;
            4: return ChBslash;
            default: return ChQuote;
        endcase
    endfunction

    // one string of random tokens, ended in one of several ways
    task automatic add_string();
        logic [7:0] s[$];
        int         ending;
        int         nd;
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(9))
                0, 1, 2: s.push_back(8'($urandom_range(32, 126)));
                3: s.push_back(8'($urandom_range(1, 255)));
                4:
                begin
                    s.push_back(ChBslash);
                    s.push_back(plain_escape());
                end
                5, 6:
                begin
                    s.push_back(ChBslash);
                    s.push_back(ChX);
                    nd = $urandom_range(4) == 0 ? 0 : $urandom_range(1, 2);
                    repeat (nd) s.push_back(hex_char($urandom_range(15)));
                end
                7, 8:
                begin
                    s.push_back(ChBslash);
                    repeat ($urandom_range(1, 3)) s.push_back(8'("0" + $urandom_range(7)));
                end
                default:
                begin
                    s.push_back(ChBslash);
                    s.push_back(8'($urandom_range(1, 255)));
                end
            endcase
        end
        ending = $urandom_range(9);
        if (ending == 8)
        begin
            s.push_back(ChBslash);
        end
        else if (ending == 9)
        begin
            s.push_back(ChBslash);
            s.push_back(ChX);
        end
        for (int i = 0; i < s.size(); i++)
        begin
            queue_char(s[i], (i == s.size() - 1) && (ending <= 5 || ending >= 8));
        end
        if (ending == 6 || ending == 7)
        begin
            queue_char(ChNul, 1'($urandom_range(1)));
        end
    endtask

    task automatic wait_drained();
        while (!(chars_q.size() == 0 && !s_axis_tvalid && expected_q.size() == 0))
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic set_limit(input logic [CntW-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        max_len_q = v;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int seg_base;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int seg = 0; seg < 6; seg++)
        begin
            tx_idle_pct = (seg < 2) ? 21 : (seg < 4) ? 46 : 0;
            rx_idle_pct = (seg < 2) ? 46 : (seg < 4) ? 21 : 0;
            case (seg)
                0: set_limit(13'd4096);
                1: set_limit(13'd0);
                2: set_limit(13'd5);
                3: set_limit(13'd4095);
                4: set_limit(13'd1);
                default: set_limit(13'd9);
            endcase
            if (seg == 0)
            begin
                push_text("\\n\\r\\t\\e", 1'b1);
                push_text("\\\\\\q", 1'b0);
                queue_char(8'hFF, 1'b1);
                push_text("\\xaF\\x7g\\x", 1'b1);
                push_text("\\777\\17", 1'b1);
                queue_char(ChNul, 1'b0);
            end
            seg_base = n_pushed;
            while (n_pushed - seg_base < SegItems)
            begin
                add_string();
            end
            wait_drained();
        end
        if (n_fail == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/esd_pkg.sv
rtl/core/esd_front.sv
rtl/core/esd_queue.sv
rtl/core/esd_back.sv
rtl/core/escape_sequence_decoder_top.sv
bench/tb_escape_sequence_decoder_top.sv
